### rtl/core/vtp_pkg.sv
// Shared types, constants and helpers for the vertex transform and projection pipeline.
package vtp_pkg;

    localparam int unsigned NUM_COLS  = 4;
    localparam int unsigned DIV_STEPS = 34;   // quotient bits kept per divide

    typedef enum logic [1:0] {
        ACT_TRANSFORM = 2'd0,
        ACT_PROJECT   = 2'd1,
        ACT_LOAD      = 2'd2,
        ACT_NONE      = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CFG_HALF_WIDTH  = 2'd0,
        CFG_HALF_HEIGHT = 2'd1,
        CFG_ORIGIN_X    = 2'd2,
        CFG_ORIGIN_Y    = 2'd3
    } cfg_index_t;

    localparam logic [30:0] HALF_WIDTH_RST  = 31'd20971520;
    localparam logic [30:0] HALF_HEIGHT_RST = 31'd15728640;
    localparam logic [30:0] ORIGIN_X_RST    = 31'd20971520;
    localparam logic [30:0] ORIGIN_Y_RST    = 31'd15728640;

    localparam logic signed [31:0] Q_ONE   = 32'sh0001_0000;
    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    // One divider lane: partial remainder, numerator bits still to shift in, quotient
    typedef struct packed {
        logic [31:0]          rem;
        logic [DIV_STEPS-1:0] low;
        logic [DIV_STEPS-1:0] quo;
    } div_lane_t;

    // Per-item flags that ride along with the divider
    typedef struct packed {
        logic                wz;
        logic [NUM_COLS-1:0] q_neg;
        logic [NUM_COLS-1:0] num_neg;
        logic [NUM_COLS-1:0] big;
    } div_side_t;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return SAT_MAX;
        else if (v < -66'sd2147483648)
            return SAT_MIN;
        else
            return v[31:0];
    endfunction

endpackage

### rtl/core/vertex_transform_project.sv
// Vertex transform, perspective divide and viewport map pipeline (top level).
//
//  channel | signals                                  | dir | handshake
//  --------+------------------------------------------+-----+-----------------
//  cfg     | cfg_we cfg_index cfg_data                | in  | write when cfg_we
//  in      | in_valid in_ready action coord_* entry_* | in  | valid/ready
//  out     | out_valid out_ready screen_x screen_y    | out | valid/ready
//          | depth recip_w w_zero                     |     |
//
// One item per cycle while out_ready does not stall; a vertex result passes these registers in order:
// product, column sum, numerator product, sign/magnitude, 34 one-bit divide steps
// (set by the quotient width kept) and the output register.
// Matrix loads take effect at the accepting edge and give no result.
// Reset (rst_n low) empties the pipe, restores the identity matrix and viewport.
// A stall on out_ready freezes every stage; in_ready follows it in the same cycle.
module vertex_transform_project (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    input  logic signed [31:0] coord_w,
    input  logic [3:0]         entry_index,
    input  logic signed [31:0] entry_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] screen_x,
    output logic signed [31:0] screen_y,
    output logic signed [31:0] depth,
    output logic signed [31:0] recip_w,
    output logic               w_zero
);

    localparam int unsigned NC = vtp_pkg::NUM_COLS;
    localparam int unsigned NS = vtp_pkg::DIV_STEPS;

    logic en;
    logic in_fire;

    // Global advance: the whole pipe moves when the output slot is free or taken
    assign en       = !out_valid || out_ready;
    assign in_ready = en;
    assign in_fire  = in_valid && in_ready;

    // Viewport registers
    logic [30:0] half_width_reg;
    logic [30:0] half_height_reg;
    logic [30:0] origin_x_reg;
    logic [30:0] origin_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg  <= vtp_pkg::HALF_WIDTH_RST;
            half_height_reg <= vtp_pkg::HALF_HEIGHT_RST;
            origin_x_reg    <= vtp_pkg::ORIGIN_X_RST;
            origin_y_reg    <= vtp_pkg::ORIGIN_Y_RST;
        end
        else if (cfg_we)
        begin
            case (vtp_pkg::cfg_index_t'(cfg_index))
                vtp_pkg::CFG_HALF_WIDTH:  half_width_reg  <= cfg_data;
                vtp_pkg::CFG_HALF_HEIGHT: half_height_reg <= cfg_data;
                vtp_pkg::CFG_ORIGIN_X:    origin_x_reg    <= cfg_data;
                vtp_pkg::CFG_ORIGIN_Y:    origin_y_reg    <= cfg_data;
                default:                  half_width_reg  <= half_width_reg;
            endcase
        end
    end

    // Matrix store, identity after reset, written by load items
    logic signed [31:0] mat_reg [16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                mat_reg[i] <= (i[1:0] == i[3:2]) ? vtp_pkg::Q_ONE : '0;
        end
        else if (in_fire && (vtp_pkg::action_t'(action) == vtp_pkg::ACT_LOAD))
        begin
            mat_reg[entry_index] <= entry_value;
        end
    end

    // Stage A: matrix products straight from the input item
    logic               vld_a_reg;
    logic               vld_a_next;
    logic               xf_a_reg;
    logic signed [63:0] prod_a_reg [NC][3];
    logic signed [63:0] prod_a_next [NC][3];
    logic signed [31:0] row3_a_reg [NC];
    logic signed [31:0] pass_a_reg [NC];

    always_comb
    begin
        vld_a_next = in_fire && ((vtp_pkg::action_t'(action) == vtp_pkg::ACT_TRANSFORM) ||
                                 (vtp_pkg::action_t'(action) == vtp_pkg::ACT_PROJECT));
        for (int c = 0; c < NC; c++)
        begin
            prod_a_next[c][0] = coord_x * mat_reg[c];
            prod_a_next[c][1] = coord_y * mat_reg[4 + c];
            prod_a_next[c][2] = coord_z * mat_reg[8 + c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xf_a_reg <= (vtp_pkg::action_t'(action) == vtp_pkg::ACT_TRANSFORM);
            for (int c = 0; c < NC; c++)
            begin
                prod_a_reg[c] <= prod_a_next[c];
                row3_a_reg[c] <= mat_reg[12 + c];
            end
            pass_a_reg[0] <= coord_x;
            pass_a_reg[1] <= coord_y;
            pass_a_reg[2] <= coord_z;
            pass_a_reg[3] <= coord_w;
        end
    end

    // Stage B: column sums, round half up, saturate; or pass the homogeneous vertex
    logic               vld_b_reg;
    logic signed [31:0] h_b_reg [NC];
    logic signed [31:0] h_b_next [NC];
    logic signed [65:0] col_sum [NC];

    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            col_sum[c] = 66'(prod_a_reg[c][0]) + 66'(prod_a_reg[c][1]) +
                         66'(prod_a_reg[c][2]) +
                         $signed({{18{row3_a_reg[c][31]}}, row3_a_reg[c], 16'h0000}) +
                         66'sd32768;
            h_b_next[c] = xf_a_reg ? vtp_pkg::sat32(col_sum[c] >>> 16) : pass_a_reg[c];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            h_b_reg <= h_b_next;
    end

    // Stage C: divide numerators
    logic               vld_c_reg;
    logic signed [63:0] num_c_reg [NC];
    logic signed [31:0] w_c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_c_reg[0] <= $signed({1'b0, half_width_reg}) * h_b_reg[0];
            num_c_reg[1] <= $signed({1'b0, half_height_reg}) * h_b_reg[1];
            num_c_reg[2] <= $signed({{16{h_b_reg[2][31]}}, h_b_reg[2], 16'h0000});
            num_c_reg[3] <= 64'sh0000_0001_0000_0000;
            w_c_reg      <= h_b_reg[3];
        end
    end

    // Divider pipe: index 0 is the sign/magnitude stage, then one quotient bit per stage
    logic [NS:0]          dvld_reg;
    vtp_pkg::div_lane_t   lane_reg [NS+1][NC];
    vtp_pkg::div_lane_t   lane_next [NS+1][NC];
    vtp_pkg::div_side_t   side_reg [NS+1];
    vtp_pkg::div_side_t   side_next0;
    logic [31:0]          d_reg [NS+1];
    logic [31:0]          wabs;
    logic [63:0]          nmag [NC];

    // Sign and magnitude, early overflow check
    always_comb
    begin
        wabs = w_c_reg[31] ? 32'(-w_c_reg) : 32'(w_c_reg);
        side_next0.wz = (w_c_reg == '0);
        for (int l = 0; l < NC; l++)
        begin
            nmag[l] = num_c_reg[l][63] ? 64'(-num_c_reg[l]) : 64'(num_c_reg[l]);
            side_next0.num_neg[l] = num_c_reg[l][63];
            side_next0.q_neg[l]   = num_c_reg[l][63] ^ w_c_reg[31];
            side_next0.big[l]     = ({2'b00, nmag[l][63:34]} >= wabs);
            lane_next[0][l].rem   = {2'b00, nmag[l][63:34]};
            lane_next[0][l].low   = nmag[l][33:0];
            lane_next[0][l].quo   = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lane_reg[0] <= lane_next[0];
            side_reg[0] <= side_next0;
            d_reg[0]    <= wabs;
        end
    end

    // Restoring divide steps
    for (genvar s = 0; s < NS; s++)
    begin : g_div
        logic [32:0] trial [NC];

        always_comb
        begin
            for (int l = 0; l < NC; l++)
            begin
                trial[l] = {lane_reg[s][l].rem, lane_reg[s][l].low[NS-1]};
                lane_next[s+1][l].low = {lane_reg[s][l].low[NS-2:0], 1'b0};
                if (trial[l] >= {1'b0, d_reg[s]})
                begin
                    lane_next[s+1][l].rem = 32'(trial[l] - {1'b0, d_reg[s]});
                    lane_next[s+1][l].quo = {lane_reg[s][l].quo[NS-2:0], 1'b1};
                end
                else
                begin
                    lane_next[s+1][l].rem = trial[l][31:0];
                    lane_next[s+1][l].quo = {lane_reg[s][l].quo[NS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                lane_reg[s+1] <= lane_next[s+1];
                side_reg[s+1] <= side_reg[s];
                d_reg[s+1]    <= d_reg[s];
            end
        end
    end

    // Final: apply sign, clamp, add origin, saturate; w zero override
    logic [NS-1:0]      qmag [NC];
    logic signed [36:0] qsgn [NC];
    logic signed [36:0] qsum [NC];
    logic signed [31:0] res_next [NC];
    logic [30:0]        offs [NC];
    logic signed [31:0] res_reg [NC];
    logic               out_valid_reg;
    logic               w_zero_reg;

    always_comb
    begin
        offs[0] = origin_x_reg;
        offs[1] = origin_y_reg;
        offs[2] = '0;
        offs[3] = '0;
        for (int l = 0; l < NC; l++)
        begin
            qmag[l] = side_reg[NS].big[l] ? '1 : lane_reg[NS][l].quo;
            qsgn[l] = side_reg[NS].q_neg[l] ? -$signed({3'b000, qmag[l]})
                                            : $signed({3'b000, qmag[l]});
            qsum[l] = qsgn[l] + $signed({6'b000000, offs[l]});
            if (side_reg[NS].wz)
                res_next[l] = side_reg[NS].num_neg[l] ? vtp_pkg::SAT_MIN : vtp_pkg::SAT_MAX;
            else
                res_next[l] = vtp_pkg::sat32(66'(qsum[l]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg    <= res_next;
            w_zero_reg <= side_reg[NS].wz;
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg     <= 1'b0;
            vld_b_reg     <= 1'b0;
            vld_c_reg     <= 1'b0;
            dvld_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg     <= vld_a_next;
            vld_b_reg     <= vld_a_reg;
            vld_c_reg     <= vld_b_reg;
            dvld_reg      <= {dvld_reg[NS-1:0], vld_c_reg};
            out_valid_reg <= dvld_reg[NS];
        end
    end

    assign out_valid = out_valid_reg;
    assign screen_x  = res_reg[0];
    assign screen_y  = res_reg[1];
    assign depth     = res_reg[2];
    assign recip_w   = res_reg[3];
    assign w_zero    = w_zero_reg;

`ifndef SYNTHESIS
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (action == vtp_pkg::ACT_LOAD)) |=> !vld_a_reg)
        else $error("load item entered the vertex pipe");

    a_wz_recip: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && w_zero) |-> (recip_w == vtp_pkg::SAT_MAX))
        else $error("w zero result without saturated reciprocal");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(dvld_reg))
        else $error("divider valid bits moved during a stall");
`endif

endmodule
